[sv/prrs_pkg.sv]
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared types and constants for the priority round-robin scheduler.
// ----------------------------------------------------------------------------
package prrs_pkg;

  localparam int SLOTS_DEF   = 64;
  localparam int SLOT_W      = 6;
  localparam int PRI_W       = 8;
  localparam int SLICE_W     = 18;
  localparam int BASE_W      = 16;
  localparam int CMD_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_RDY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_PRI = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET_CUR = 3'd5;
  localparam logic [CMD_W-1:0] CMD_YIELD   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_PICK    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_PREEMPT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REALTIME = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // capture request
    logic rd_cur;     // read memory at current index
    logic rd_req;     // read memory at request slot
    logic exec;       // apply command (uses registered read data)
    logic scan_start; // clear scan best
    logic scan_step;  // evaluate one slot
    logic finish;     // commit tick/pick outcome, build result
  } prrs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic is_pick;
    logic is_yield;
    logic tick_live;  // tick has work
    logic need_scan;  // tick expired slice
    logic scan_last;
  } prrs_sts_t;

endpackage

[sv/prrs_datapath.sv]
// ----------------------------------------------------------------------------
// prrs_datapath
// Task table, configuration registers, scan unit and result register.
// ----------------------------------------------------------------------------
module prrs_datapath #(
  parameter int SLOTS = prrs_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  prrs_pkg::prrs_cmd_t               cmd,
  output prrs_pkg::prrs_sts_t               sts,
  input  logic                              cfg_we,
  input  logic [prrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prrs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [prrs_pkg::CMD_W-1:0]        in_command,
  input  logic [prrs_pkg::SLOT_W-1:0]       in_slot,
  input  logic [prrs_pkg::PRI_W-1:0]        in_priority_req,
  input  logic                              in_ready_flag,
  input  logic                              in_current_none,
  output logic                              res_switch_request,
  output logic                              res_next_found,
  output logic [prrs_pkg::SLOT_W-1:0]       res_next_slot
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW = prrs_pkg::SLOT_W;
  localparam int PW = prrs_pkg::PRI_W;
  localparam int LW = prrs_pkg::SLICE_W;

  // config
  logic          preempt_r;
  logic [15:0]   base_r;
  logic [PW-1:0] idle_r, high_r, rt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preempt_r <= 1'b1;
      base_r    <= 16'd10;
      idle_r    <= 8'd0;
      high_r    <= 8'd2;
      rt_r      <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prrs_pkg::REG_PREEMPT:  preempt_r <= cfg_data[0];
        prrs_pkg::REG_BASE:     base_r    <= cfg_data;
        prrs_pkg::REG_IDLE:     idle_r    <= cfg_data[PW-1:0];
        prrs_pkg::REG_HIGH:     high_r    <= cfg_data[PW-1:0];
        prrs_pkg::REG_REALTIME: rt_r      <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic [2:0]    cmd_r;
  logic [SW-1:0] slot_r;
  logic [PW-1:0] preq_r;
  logic          rdy_r, none_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cmd_r  <= in_command;
      slot_r <= in_slot;
      preq_r <= in_priority_req;
      rdy_r  <= in_ready_flag;
      none_r <= in_current_none;
    end
  end

  // flags and control
  logic [SLOTS-1:0] valid_r, ready_r;
  logic             cur_valid_r;
  logic [IW-1:0]    cur_idx_r;
  logic [IW-1:0]    cursor_r;

  // memories (priority, slice, remaining)
  logic [PW-1:0] pri_mem [SLOTS];
  logic [LW-1:0] slc_mem [SLOTS];
  logic [LW-1:0] rem_mem [SLOTS];

  logic          in_range;
  logic [IW-1:0] req_idx;
  assign in_range = ({{(32-SW){1'b0}}, slot_r} < SLOTS);
  assign req_idx  = IW'(slot_r);

  logic cur_live;
  assign cur_live = cur_valid_r & valid_r[cur_idx_r];

  // registered read port
  logic [IW-1:0] rd_addr;
  logic [PW-1:0] rd_pri_r;
  logic [LW-1:0] rd_slc_r, rd_rem_r;
  assign rd_addr = cmd.rd_cur ? cur_idx_r : req_idx;

  // scan read port
  logic [IW-1:0] scan_i_r;
  logic [PW-1:0] scan_pri_r;

  // write port
  logic          we_pri, we_slc, we_rem;
  logic [IW-1:0] wr_addr;
  logic [PW-1:0] wr_pri;
  logic [LW-1:0] wr_slc, wr_rem;

  always_ff @(posedge clk) begin
    if (cmd.rd_cur || cmd.rd_req) begin
      rd_pri_r <= pri_mem[rd_addr];
      rd_slc_r <= slc_mem[rd_addr];
      rd_rem_r <= rem_mem[rd_addr];
    end
    scan_pri_r <= pri_mem[scan_i_r];
    if (we_pri) pri_mem[wr_addr] <= wr_pri;
    if (we_slc) slc_mem[wr_addr] <= wr_slc;
    if (we_rem) rem_mem[wr_addr] <= wr_rem;
  end

  // band reload value
  logic [LW-1:0] band_slice;
  always_comb begin
    priority if (rd_pri_r >= rt_r)   band_slice = {base_r, 2'b00};
    else if (rd_pri_r >= high_r)     band_slice = {1'b0, base_r, 1'b0};
    else                             band_slice = {2'b00, base_r};
  end

  logic [LW-1:0] dec_rem;
  assign dec_rem = (rd_rem_r != '0) ? rd_rem_r - LW'(1) : rd_rem_r;

  // tick state: whether the tick expired the slice, held until finish
  logic expired_r;

  assign sts.is_tick   = (cmd_r == prrs_pkg::CMD_TICK);
  assign sts.is_pick   = (cmd_r == prrs_pkg::CMD_PICK);
  assign sts.is_yield  = (cmd_r == prrs_pkg::CMD_YIELD);
  assign sts.tick_live = preempt_r & cur_live;
  assign sts.need_scan = (dec_rem == '0);
  assign sts.scan_last = (scan_i_r == IW'(SLOTS - 1));

  // scan unit: one slot per cycle; scan_v_r marks scan_pri_r as valid for
  // the slot in scan_idx_r
  logic          scan_v_r;
  logic [IW-1:0] scan_idx_r;
  logic          found_r;
  logic [IW-1:0] best_r;
  logic [PW-1:0] best_pri_r;

  logic elig;
  assign elig = valid_r[scan_idx_r] & ready_r[scan_idx_r] &
                !(cur_valid_r && scan_idx_r == cur_idx_r) &
                (scan_pri_r >= idle_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_v_r <= 1'b0;
    end else begin
      scan_v_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_i_r;
    if (cmd.scan_start) begin
      scan_i_r <= '0;
    end else if (cmd.scan_step && !sts.scan_last) begin
      scan_i_r <= scan_i_r + IW'(1);
    end
    if (cmd.scan_start) begin
      found_r    <= 1'b0;
      best_r     <= '0;
      best_pri_r <= '0;
    end else if (scan_v_r && elig) begin
      if (!found_r || scan_pri_r > best_pri_r) begin
        found_r    <= 1'b1;
        best_r     <= scan_idx_r;
        best_pri_r <= scan_pri_r;
      end else if (scan_pri_r == best_pri_r && scan_idx_r > cursor_r &&
                   best_r <= cursor_r) begin
        best_r <= scan_idx_r;
      end
    end
  end

  // command execution
  always_comb begin
    we_pri  = 1'b0;
    we_slc  = 1'b0;
    we_rem  = 1'b0;
    wr_addr = req_idx;
    wr_pri  = preq_r;
    wr_slc  = {2'b00, base_r};
    wr_rem  = {2'b00, base_r};
    if (cmd.exec) begin
      unique case (cmd_r)
        prrs_pkg::CMD_TICK: begin
          if (sts.tick_live) begin
            wr_addr = cur_idx_r;
            we_rem  = 1'b1;
            if (sts.need_scan) begin
              we_slc = 1'b1;
              wr_slc = band_slice;
              wr_rem = band_slice;
            end else begin
              wr_rem = dec_rem;
            end
          end
        end
        prrs_pkg::CMD_LOAD: begin
          we_pri = in_range;
          we_slc = in_range;
          we_rem = in_range;
        end
        prrs_pkg::CMD_SET_PRI: begin
          if (in_range && valid_r[req_idx]) begin
            we_pri = 1'b1;
            we_rem = 1'b1;
            wr_pri = (preq_r > rt_r) ? rt_r : preq_r;
            wr_rem = rd_slc_r;
          end
        end
        prrs_pkg::CMD_YIELD: begin
          if (cur_live) begin
            wr_addr = cur_idx_r;
            we_slc  = 1'b1;
            we_rem  = 1'b1;
            wr_slc  = band_slice;
            wr_rem  = band_slice;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ready_r     <= '0;
      cur_valid_r <= 1'b0;
      cur_idx_r   <= '0;
      cursor_r    <= '0;
      expired_r   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        expired_r <= sts.is_tick & sts.tick_live & sts.need_scan;
        unique case (cmd_r)
          prrs_pkg::CMD_LOAD: begin
            if (in_range) begin
              valid_r[req_idx] <= 1'b1;
              ready_r[req_idx] <= rdy_r;
            end
          end
          prrs_pkg::CMD_FREE: begin
            if (in_range) begin
              valid_r[req_idx] <= 1'b0;
              ready_r[req_idx] <= 1'b0;
            end
          end
          prrs_pkg::CMD_SET_RDY: begin
            if (in_range && valid_r[req_idx]) ready_r[req_idx] <= rdy_r;
          end
          prrs_pkg::CMD_SET_CUR: begin
            if (none_r) begin
              cur_valid_r <= 1'b0;
            end else if (in_range) begin
              cur_valid_r <= 1'b1;
              cur_idx_r   <= req_idx;
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish && sts.is_tick && expired_r && found_r) begin
        cursor_r <= (cur_idx_r == IW'(SLOTS - 1)) ? '0 : cur_idx_r + IW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_switch_request <= 1'b0;
      res_next_found     <= 1'b0;
      res_next_slot      <= '0;
      if ((sts.is_pick || (sts.is_tick && expired_r)) && found_r) begin
        res_switch_request <= sts.is_tick;
        res_next_found     <= 1'b1;
        res_next_slot      <= SW'(best_r);
      end
    end
  end

endmodule

[sv/prrs_ctrl.sv]
// ----------------------------------------------------------------------------
// prrs_ctrl
// Sequencer: accepts a request, reads the table, scans if needed, delivers.
// ----------------------------------------------------------------------------
module prrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output prrs_pkg::prrs_cmd_t cmd,
  input  prrs_pkg::prrs_sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DRN1 = 3'd4;
  localparam logic [2:0] S_DRN2 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  logic busy_out;
  assign busy_out = ovalid_r & ~out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r & ~out_ready;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        // tick and yield read the current entry
        cmd.rd_cur = sts.is_tick | sts.is_yield;
        cmd.rd_req = ~(sts.is_tick | sts.is_yield);
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.scan_start = 1'b1;
        if (sts.is_pick || (sts.is_tick && sts.tick_live && sts.need_scan)) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DRN1;
      end
      S_DRN1: state_nxt = S_DRN2;
      S_DRN2: state_nxt = S_FIN;
      S_FIN: begin
        if (!busy_out) begin
          cmd.finish = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

[sv/priority_round_robin_scheduler.sv]
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler
// Task table scheduler with priority pick, round-robin ties and time slices.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per command (tick, load, free, set ready, set
//           priority, set current, yield, pick), valid/ready handshake.
//   out_* : one result per request: switch_request, next_found, next_slot.
//   cfg_* : register writes (index 0..4), taken at any time, intended
//           while the block is idle.
// Sequence: commands without a scan step through read, execute and finish;
//   pick and expiring ticks scan the table one slot per cycle through the
//   priority memory read port, then drain (S_DRN1, S_DRN2) before finish.
// Throughput: one request at a time; in_ready rises together with out_valid.
// Reset: all entries invalid, no current entry, cursor zero, registers at
//   defaults. A stalled receiver holds out_valid and the result; the next
//   request is processed but waits in the sequencer until the output drains.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler #(
  parameter int SLOTS = prrs_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [prrs_pkg::CMD_W-1:0]      in_command,
  input  logic [prrs_pkg::SLOT_W-1:0]     in_slot,
  input  logic [prrs_pkg::PRI_W-1:0]      in_priority_req,
  input  logic                            in_ready_flag,
  input  logic                            in_current_none,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_switch_request,
  output logic                            out_next_found,
  output logic [prrs_pkg::SLOT_W-1:0]     out_next_slot,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prrs_pkg::CFG_DATA_W-1:0] cfg_data
);
  prrs_pkg::prrs_cmd_t cmd;
  prrs_pkg::prrs_sts_t sts;

  assign cfg_ready = 1'b1;

  prrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  prrs_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_command         (in_command),
    .in_slot            (in_slot),
    .in_priority_req    (in_priority_req),
    .in_ready_flag      (in_ready_flag),
    .in_current_none    (in_current_none),
    .res_switch_request (out_switch_request),
    .res_next_found     (out_next_found),
    .res_next_slot      (out_next_slot)
  );

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the priority round-robin scheduler: directed commands, a
// zero-slice test, then random command mixes under several register settings,
// with results checked against an in-bench table model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = prrs_pkg::SLOTS_DEF;
  localparam int CW    = prrs_pkg::CMD_W;
  localparam int SW    = prrs_pkg::SLOT_W;
  localparam int PW    = prrs_pkg::PRI_W;
  localparam int LW    = prrs_pkg::SLICE_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CW-1:0] in_command = '0;
  logic [SW-1:0] in_slot = '0;
  logic [PW-1:0] in_priority_req = '0;
  logic in_ready_flag = 1'b0;
  logic in_current_none = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_switch_request;
  logic out_next_found;
  logic [SW-1:0] out_next_slot;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [prrs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [prrs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  priority_round_robin_scheduler dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic sw;
    logic found;
    logic [SW-1:0] slot;
  } sched_res_t;

  // scheduler model state
  logic m_preempt;
  logic [prrs_pkg::BASE_W-1:0] m_base;
  logic [PW-1:0] m_idle, m_high, m_rt;
  logic m_valid[NSLOT];
  logic m_rdy[NSLOT];
  logic [PW-1:0] m_pri[NSLOT];
  logic [LW-1:0] m_slice[NSLOT];
  logic [LW-1:0] m_rem[NSLOT];
  logic m_cur_v;
  logic [SW-1:0] m_cur;
  logic [SW-1:0] m_cursor;

  sched_res_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_switch = 0;
  int n_found = 0;

  function automatic void reload_slice(int s);
    logic [2:0] mult;
    mult = 3'd1;
    if (m_pri[s] >= m_rt) mult = 3'd4;
    else if (m_pri[s] >= m_high) mult = 3'd2;
    m_slice[s] = LW'(m_base) * LW'(mult);
    m_rem[s] = m_slice[s];
  endfunction

  function automatic logic pick_best(output logic [SW-1:0] best);
    logic found;
    logic [PW-1:0] bp;
    found = 1'b0;
    bp = '0;
    best = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!m_valid[i] || !m_rdy[i]) continue;
      if (m_cur_v && i == m_cur) continue;
      if (m_pri[i] < m_idle) continue;
      if (!found || m_pri[i] > bp) begin
        found = 1'b1;
        best = SW'(i);
        bp = m_pri[i];
      end else if (m_pri[i] == bp && i > m_cursor && best <= m_cursor) begin
        best = SW'(i);
      end
    end
    return found;
  endfunction

  function automatic logic cur_live();
    return m_cur_v && m_valid[m_cur];
  endfunction

  function automatic sched_res_t schedule_step(logic [CW-1:0] cmd, logic [SW-1:0] s,
                                               logic [PW-1:0] p, logic rf, logic nn);
    sched_res_t r;
    logic [SW-1:0] n;
    r = '0;
    case (cmd)
      prrs_pkg::CMD_TICK: begin
        if (m_preempt && cur_live()) begin
          if (m_rem[m_cur] > 0) m_rem[m_cur]--;
          if (m_rem[m_cur] == 0) begin
            if (pick_best(n)) begin
              m_cursor = m_cur + 1'b1;
              r.sw = 1'b1;
              r.found = 1'b1;
              r.slot = n;
            end
            reload_slice(m_cur);
          end
        end
      end
      prrs_pkg::CMD_LOAD: begin
        m_valid[s] = 1'b1;
        m_rdy[s] = rf;
        m_pri[s] = p;
        m_slice[s] = LW'(m_base);
        m_rem[s] = LW'(m_base);
      end
      prrs_pkg::CMD_FREE: begin
        m_valid[s] = 1'b0;
        m_rdy[s] = 1'b0;
      end
      prrs_pkg::CMD_SET_RDY: if (m_valid[s]) m_rdy[s] = rf;
      prrs_pkg::CMD_SET_PRI: begin
        if (m_valid[s]) begin
          m_pri[s] = (p > m_rt) ? m_rt : p;
          m_rem[s] = m_slice[s];
        end
      end
      prrs_pkg::CMD_SET_CUR: begin
        if (nn) m_cur_v = 1'b0;
        else begin
          m_cur_v = 1'b1;
          m_cur = s;
        end
      end
      prrs_pkg::CMD_YIELD: if (cur_live()) reload_slice(m_cur);
      default: begin
        if (pick_best(n)) begin
          r.found = 1'b1;
          r.slot = n;
        end
      end
    endcase
    return r;
  endfunction

  // in_valid stays high when the next request follows at once; write_reg and
  // the end of the run drop it
  task automatic send_request(logic [CW-1:0] cmd, logic [SW-1:0] s,
                              logic [PW-1:0] p = '0, logic rf = 1'b0, logic nn = 1'b0);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_slot <= s;
    in_priority_req <= p;
    in_ready_flag <= rf;
    in_current_none <= nn;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(schedule_step(cmd, s, p, rf, nn));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [prrs_pkg::CFG_IDX_W-1:0] idx,
                           logic [prrs_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (NSLOT + 10) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      prrs_pkg::REG_PREEMPT: m_preempt = val[0];
      prrs_pkg::REG_BASE: m_base = val;
      prrs_pkg::REG_IDLE: m_idle = val[7:0];
      prrs_pkg::REG_HIGH: m_high = val[7:0];
      prrs_pkg::REG_REALTIME: m_rt = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic pe, logic [15:0] base, logic [7:0] idle,
                            logic [7:0] hi, logic [7:0] rt);
    write_reg(prrs_pkg::REG_PREEMPT, 16'(pe));
    write_reg(prrs_pkg::REG_BASE, base);
    write_reg(prrs_pkg::REG_IDLE, 16'(idle));
    write_reg(prrs_pkg::REG_HIGH, 16'(hi));
    write_reg(prrs_pkg::REG_REALTIME, 16'(rt));
  endtask

  // receiver: takes each result after a random stall
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      while (!out_valid) @(negedge clk);
      stall = $urandom_range(0, 5);
      repeat (stall) @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      @(negedge clk);
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        sched_res_t e;
        e = expected_q.pop_front();
        n_results++;
        if (e.sw) n_switch++;
        if (e.found) n_found++;
        if (out_switch_request !== e.sw) begin
          $error("switch_request exp %0d got %0d", e.sw, out_switch_request);
          errors++;
        end
        if (out_next_found !== e.found) begin
          $error("next_found exp %0d got %0d", e.found, out_next_found);
          errors++;
        end
        if (out_next_slot !== e.slot) begin
          $error("next_slot exp %0d got %0d", e.slot, out_next_slot);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(prrs_pkg::CMD_PICK, 0);
    send_request(prrs_pkg::CMD_TICK, 0);
    send_request(prrs_pkg::CMD_LOAD, 0, 8'd0, 1'b1);
    send_request(prrs_pkg::CMD_LOAD, 63, 8'd255, 1'b1);
    send_request(prrs_pkg::CMD_LOAD, 5, 8'd255, 1'b0);
    send_request(prrs_pkg::CMD_SET_RDY, 5, 8'd0, 1'b1);
    send_request(prrs_pkg::CMD_SET_RDY, 7, 8'd0, 1'b1);
    send_request(prrs_pkg::CMD_SET_PRI, 63, 8'd200);
    send_request(prrs_pkg::CMD_SET_PRI, 9, 8'd1);
    send_request(prrs_pkg::CMD_PICK, 0);
    send_request(prrs_pkg::CMD_SET_CUR, 63);
    send_request(prrs_pkg::CMD_PICK, 0);
    repeat (12) send_request(prrs_pkg::CMD_TICK, 0);
    send_request(prrs_pkg::CMD_YIELD, 0);
    send_request(prrs_pkg::CMD_FREE, 63);
    send_request(prrs_pkg::CMD_TICK, 0);
    send_request(prrs_pkg::CMD_YIELD, 0);
    send_request(prrs_pkg::CMD_SET_CUR, 0, 8'd0, 1'b0, 1'b1);
    send_request(prrs_pkg::CMD_TICK, 0);
    send_request(prrs_pkg::CMD_PICK, 0);
  endtask

  task automatic test_zero_slice();
    set_config(1'b1, 16'd0, 8'd0, 8'd2, 8'd3);
    send_request(prrs_pkg::CMD_LOAD, 1, 8'd1, 1'b1);
    send_request(prrs_pkg::CMD_LOAD, 2, 8'd1, 1'b1);
    send_request(prrs_pkg::CMD_SET_CUR, 1);
    repeat (3) send_request(prrs_pkg::CMD_TICK, 0);
    send_request(prrs_pkg::CMD_YIELD, 0);
    send_request(prrs_pkg::CMD_TICK, 0);
  endtask

  // random tables: few slots most of the time so ties and expiries are common
  task automatic test_random(int items);
    int span;
    logic [CW-1:0] c;
    logic [SW-1:0] s;
    span = ($urandom_range(0, 3) == 0) ? NSLOT : $urandom_range(2, 8);
    for (int k = 0; k < items; k++) begin
      s = SW'($urandom_range(0, span - 1));
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4, 5: c = prrs_pkg::CMD_TICK;
        6, 7: c = prrs_pkg::CMD_LOAD;
        8: c = prrs_pkg::CMD_FREE;
        9: c = prrs_pkg::CMD_SET_RDY;
        10: c = prrs_pkg::CMD_SET_PRI;
        11: c = prrs_pkg::CMD_SET_CUR;
        12: c = prrs_pkg::CMD_YIELD;
        default: c = prrs_pkg::CMD_PICK;
      endcase
      send_request(c, s, 8'($urandom_range(0, 255) % ($urandom_range(0, 1) ? 256 : 6)),
                   1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    m_preempt = 1'b1;
    m_base = 16'd10;
    m_idle = 8'd0;
    m_high = 8'd2;
    m_rt = 8'd3;
    for (int i = 0; i < NSLOT; i++) begin
      m_valid[i] = 1'b0;
      m_rdy[i] = 1'b0;
      m_pri[i] = '0;
      m_slice[i] = '0;
      m_rem[i] = '0;
    end
    m_cur_v = 1'b0;
    m_cur = '0;
    m_cursor = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_zero_slice();
    set_config(1'b1, 16'd65535, 8'd255, 8'd255, 8'd255);
    test_random(150);
    set_config(1'b0, 16'd1, 8'd0, 8'd0, 8'd0);
    test_random(150);
    set_config(1'b1, 16'd2, 8'd0, 8'd2, 8'd3);
    test_random(450);
    set_config(1'b1, 16'd3, 8'd1, 8'd3, 8'd5);
    test_random(450);
    set_config(1'b1, 16'd1, 8'd0, 8'd100, 8'd200);
    test_random(400);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (NSLOT + 10) @(negedge clk);
    $display("Checked %0d results: %0d switches, %0d picks or switches found a slot,",
             n_results, n_switch, n_found);
    $display("over five register settings including the extremes.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
